// ----- rtl/fba_pkg.sv -----
// Shared constants and types of the frame bitmap allocator.
`default_nettype none

package fba_pkg;

  localparam int MAX_FRAMES   = 4096;
  localparam int WORD_BITS    = 32;
  localparam int BITMAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW      = $clog2(BITMAP_WORDS);
  localparam int BIT_AW       = $clog2(WORD_BITS);
  localparam int FRAME_W      = 12;
  localparam int CFG_W        = 13;
  localparam int REQ_W        = 2;

  localparam logic [CFG_W-1:0] FRAME_LIMIT = CFG_W'(MAX_FRAMES);

  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TEST  = 2'd2;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_IGNORED = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/frame_bitmap_allocator.sv -----
// Top level of the frame bitmap allocator: request sequencer and bitmap store.
//
// A request transaction is taken when start is high and busy is low. Its single result is
// on the ports for exactly one cycle with done high, and the receiver cannot hold it off.
// An ignored allocate, an allocate with a frame limit of zero, a free of frame zero and a
// reserved request type answer without leaving the idle state, and busy does not rise for
// them. Free and test requests read the RAM word in the idle state, then modify or report
// it in ST_FREE or ST_TEST. Otherwise an allocate reads one 32-bit bitmap word per cycle
// through the single RAM read port, skipping full words, and stops at the first clear bit
// below the frame limit, or after the last word below the limit. busy drops as done rises,
// so a new request can be taken at the edge that takes the result.
// The frames_in_use register is written over its own always-ready valid/ready channel;
// the user must write it only while no request is in flight; the block does not check it.
// Reset returns the sequencer to idle, sets frames_in_use to 4096 and marks every bitmap
// word invalid, so that all frames read as free at once with no clearing pass.
`default_nettype none

module frame_bitmap_allocator
  import fba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [REQ_W-1:0]   req_type,
  input  wire logic [FRAME_W-1:0] current_frame,
  input  wire logic [FRAME_W-1:0] frame_number,
  input  wire logic               for_kernel,
  input  wire logic               writable,
  output logic                    done,
  output logic [1:0]              status,
  output logic [FRAME_W-1:0]      granted_frame,
  output logic                    page_present,
  output logic                    page_rw,
  output logic                    page_user,
  output logic                    frame_used,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_TEST
  } state_t;

  state_t                  state;
  logic [CFG_W-1:0]        frames_in_use;
  logic [BITMAP_WORDS-1:0] word_valid;
  logic                    rd_valid;
  logic [WORD_AW-1:0]      scan_word;
  logic [BIT_AW-1:0]       bit_sel;
  logic                    req_kernel;
  logic                    req_writable;

  logic [CFG_W-1:0]     limit;
  logic [WORD_AW-1:0]   ram_raddr;
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] word_data;
  logic                 zero_found;
  logic [BIT_AW-1:0]    zero_bit;
  logic [FRAME_W-1:0]   cand_frame;
  logic                 cand_ok;
  logic [WORD_AW:0]     next_word;
  logic [CFG_W-1:0]     next_base;
  logic                 last_word;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign limit     = (frames_in_use > FRAME_LIMIT) ? FRAME_LIMIT : frames_in_use;
  assign word_data = rd_valid ? ram_rdata : '0;
  assign zero_found = (word_data != '1);
  assign cand_frame = FRAME_W'({scan_word, zero_bit});
  assign cand_ok    = ({1'b0, cand_frame} < limit);
  assign next_word  = {1'b0, scan_word} + 1'b1;
  assign next_base  = CFG_W'({next_word, {BIT_AW{1'b0}}});
  assign last_word  = (scan_word == WORD_AW'(BITMAP_WORDS - 1)) || (next_base >= limit);

  always_comb begin
    zero_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_data[i]) begin
        zero_bit = BIT_AW'(i);
      end
    end
  end

  always_comb begin
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_wdata = word_data;
    case (state)
      ST_IDLE: begin
        if (req_type != REQ_ALLOC) begin
          ram_raddr = frame_number[FRAME_W-1:BIT_AW];
        end
      end
      ST_SCAN: begin
        ram_raddr = next_word[WORD_AW-1:0];
        ram_we    = zero_found && cand_ok;
        ram_wdata = word_data | (WORD_BITS'(1) << zero_bit);
      end
      ST_FREE: begin
        ram_we    = 1'b1;
        ram_wdata = word_data & ~(WORD_BITS'(1) << bit_sel);
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  fba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(BITMAP_WORDS)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .waddr(scan_word),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    done     <= 1'b0;
    rd_valid <= word_valid[ram_raddr];
    if (ram_we) begin
      word_valid[scan_word] <= 1'b1;
    end
    if (cfg_valid && cfg_ready) begin
      frames_in_use <= cfg_data;
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          req_kernel    <= for_kernel;
          req_writable  <= writable;
          scan_word     <= frame_number[FRAME_W-1:BIT_AW];
          bit_sel       <= frame_number[BIT_AW-1:0];
          status        <= STATUS_IGNORED;
          granted_frame <= '0;
          page_present  <= 1'b0;
          page_rw       <= 1'b0;
          page_user     <= 1'b0;
          frame_used    <= 1'b0;
          case (req_type)
            REQ_ALLOC: begin
              scan_word <= '0;
              if (current_frame != '0) begin
                done <= 1'b1;
              end else if (limit == '0) begin
                status <= STATUS_FULL;
                done   <= 1'b1;
              end else begin
                state <= ST_SCAN;
              end
            end
            REQ_FREE: begin
              if (frame_number == '0) begin
                done <= 1'b1;
              end else begin
                state <= ST_FREE;
              end
            end
            REQ_TEST: begin
              state <= ST_TEST;
            end
            default: begin
              done <= 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (zero_found) begin
          state <= ST_IDLE;
          done  <= 1'b1;
          if (cand_ok) begin
            status        <= STATUS_DONE;
            granted_frame <= cand_frame;
            page_present  <= 1'b1;
            page_rw       <= req_writable;
            page_user     <= ~req_kernel;
          end else begin
            status <= STATUS_FULL;
          end
        end else if (last_word) begin
          state  <= ST_IDLE;
          done   <= 1'b1;
          status <= STATUS_FULL;
        end else begin
          scan_word <= next_word[WORD_AW-1:0];
        end
      end
      ST_FREE: begin
        state  <= ST_IDLE;
        done   <= 1'b1;
        status <= STATUS_DONE;
      end
      ST_TEST: begin
        state      <= ST_IDLE;
        done       <= 1'b1;
        status     <= STATUS_DONE;
        frame_used <= word_data[bit_sel];
      end
      default: begin
        state <= ST_IDLE;
      end
    endcase
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      word_valid    <= '0;
      frames_in_use <= CFG_W'(4096);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fba_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- tb/frame_bitmap_allocator_checker.sv -----
// Checker for the frame bitmap allocator: predicts each answer and compares it with the block.
`timescale 1ns / 1ps

module frame_bitmap_allocator_checker
  import fba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [REQ_W-1:0]   req_type,
  input  wire logic [FRAME_W-1:0] current_frame,
  input  wire logic [FRAME_W-1:0] frame_number,
  input  wire logic               for_kernel,
  input  wire logic               writable,
  input  wire logic               done,
  input  wire logic [1:0]         status,
  input  wire logic [FRAME_W-1:0] granted_frame,
  input  wire logic               page_present,
  input  wire logic               page_rw,
  input  wire logic               page_user,
  input  wire logic               frame_used,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output int                      mismatches,
  output int                      awaiting,
  output int                      granted_count,
  output int                      full_count
);

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               rw;
    logic               user;
    logic               used;
  } answer_t;

  logic [WORD_BITS-1:0] used_map [BITMAP_WORDS];
  logic [CFG_W-1:0]     managed_frames;
  answer_t              awaited_answers [$];

  // Applies one request to the local bitmap and returns the answer it must produce.
  function automatic answer_t predict_answer(input logic [REQ_W-1:0] rq,
                                             input logic [FRAME_W-1:0] cur,
                                             input logic [FRAME_W-1:0] fn,
                                             input logic kern,
                                             input logic wr);
    answer_t a;
    int      lim;
    int      f;
    int      pick;
    bit      found;
    a = '0;
    a.status = STATUS_IGNORED;
    pick = 0;
    found = 1'b0;
    case (rq)
      REQ_ALLOC: begin
        if (cur == '0) begin
          lim = managed_frames;
          if (lim > MAX_FRAMES) lim = MAX_FRAMES;
          if (lim > (1 << FRAME_W)) lim = 1 << FRAME_W;
          for (f = 0; f < lim && !found; f++) begin
            if (!used_map[f / WORD_BITS][f % WORD_BITS]) begin
              found = 1'b1;
              pick = f;
            end
          end
          if (found) begin
            used_map[pick / WORD_BITS][pick % WORD_BITS] = 1'b1;
            a.status  = STATUS_DONE;
            a.frame   = FRAME_W'(pick);
            a.present = 1'b1;
            a.rw      = wr;
            a.user    = ~kern;
          end else begin
            a.status = STATUS_FULL;
          end
        end
      end
      REQ_FREE: begin
        if (fn != '0 && int'(fn) < MAX_FRAMES) begin
          used_map[fn[FRAME_W-1:BIT_AW]][fn[BIT_AW-1:0]] = 1'b0;
          a.status = STATUS_DONE;
        end
      end
      REQ_TEST: begin
        a.status = STATUS_DONE;
        if (int'(fn) < MAX_FRAMES) a.used = used_map[fn[FRAME_W-1:BIT_AW]][fn[BIT_AW-1:0]];
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (rst) begin
      for (int w = 0; w < BITMAP_WORDS; w++) used_map[w] = '0;
      managed_frames = FRAME_LIMIT;
      awaited_answers.delete();
    end else begin
      if (done) begin
        got.status  = status_t'(status);
        got.frame   = granted_frame;
        got.present = page_present;
        got.rw      = page_rw;
        got.user    = page_user;
        got.used    = frame_used;
        if (awaited_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: answer with none expected: status %0d frame %0d p/rw/u %b%b%b used %b",
                     $realtime, got.status, got.frame, got.present, got.rw, got.user, got.used);
        end else begin
          want = awaited_answers.pop_front();
          if (want.status == STATUS_DONE && want.present) granted_count++;
          if (want.status == STATUS_FULL) full_count++;
          if (got.status !== want.status || got.frame !== want.frame ||
              got.present !== want.present || got.rw !== want.rw ||
              got.user !== want.user || got.used !== want.used) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: answer mismatch: expected status %0d frame %0d p/rw/u %b%b%b",
                       $realtime, want.status, want.frame, want.present, want.rw, want.user,
                       " used %b, got status %0d frame %0d p/rw/u %b%b%b used %b",
                       want.used, got.status, got.frame, got.present, got.rw, got.user,
                       got.used);
          end
        end
      end
      if (cfg_valid && cfg_ready) managed_frames = cfg_data;
      if (start && !busy)
        awaited_answers.push_back(predict_answer(req_type, current_frame, frame_number,
                                                 for_kernel, writable));
    end
    awaiting = awaited_answers.size();
  end

endmodule

// ----- tb/frame_bitmap_allocator_test.sv -----
// Testbench top for the frame bitmap allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module frame_bitmap_allocator_test
  import fba_pkg::*;
();

  localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   req_type;
  logic [FRAME_W-1:0] current_frame;
  logic [FRAME_W-1:0] frame_number;
  logic               for_kernel;
  logic               writable;
  logic               done;
  logic [1:0]         status;
  logic [FRAME_W-1:0] granted_frame;
  logic               page_present;
  logic               page_rw;
  logic               page_user;
  logic               frame_used;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;

  int mismatches;
  int awaiting;
  int granted_count;
  int full_count;
  int requests_sent;
  int limit_writes;

  frame_bitmap_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .current_frame (current_frame),
    .frame_number  (frame_number),
    .for_kernel    (for_kernel),
    .writable      (writable),
    .done          (done),
    .status        (status),
    .granted_frame (granted_frame),
    .page_present  (page_present),
    .page_rw       (page_rw),
    .page_user     (page_user),
    .frame_used    (frame_used),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  frame_bitmap_allocator_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .current_frame (current_frame),
    .frame_number  (frame_number),
    .for_kernel    (for_kernel),
    .writable      (writable),
    .done          (done),
    .status        (status),
    .granted_frame (granted_frame),
    .page_present  (page_present),
    .page_rw       (page_rw),
    .page_user     (page_user),
    .frame_used    (frame_used),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .awaiting      (awaiting),
    .granted_count (granted_count),
    .full_count    (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("frame_bitmap_allocator_test: done, errors");
    $finish;
  end

  task automatic issue(input logic [REQ_W-1:0] rq, input logic [FRAME_W-1:0] cur,
                       input logic [FRAME_W-1:0] fn, input logic kern, input logic wr);
    @(negedge clk);
    start         <= 1'b1;
    req_type      <= rq;
    current_frame <= cur;
    frame_number  <= fn;
    for_kernel    <= kern;
    writable      <= wr;
    do @(posedge clk); while (busy);
    requests_sent++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limit(input int value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= CFG_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  function automatic logic [FRAME_W-1:0] pick_frame(input int hi);
    if ($urandom_range(0, 9) < 7) return FRAME_W'($urandom_range(0, hi));
    return FRAME_W'($urandom);
  endfunction

  task automatic random_request(input int lim_eff);
    int                 roll;
    int                 hi;
    logic [FRAME_W-1:0] cur;
    roll = $urandom_range(0, 99);
    hi = lim_eff + 31;
    if (hi > 4095) hi = 4095;
    if (roll < 55) begin
      cur = ($urandom_range(0, 99) < 85) ? '0 : FRAME_W'($urandom_range(1, 4095));
      issue(REQ_ALLOC, cur, FRAME_W'($urandom), 1'($urandom), 1'($urandom));
    end else if (roll < 75) begin
      issue(REQ_FREE, FRAME_W'($urandom), pick_frame(hi), 1'($urandom), 1'($urandom));
    end else if (roll < 95) begin
      issue(REQ_TEST, FRAME_W'($urandom), pick_frame(hi), 1'($urandom), 1'($urandom));
    end else begin
      issue(REQ_RESERVED, FRAME_W'($urandom), FRAME_W'($urandom), 1'($urandom),
            1'($urandom));
    end
  endtask

  initial begin
    int settings [10];
    int lim_eff;
    int burst;
    settings = '{37, 8191, 64, 0, 300, 4096, 129, 1, 33, 0};
    settings[9] = $urandom_range(0, 8191);
    rst           = 1'b1;
    start         = 1'b0;
    req_type      = REQ_ALLOC;
    current_frame = '0;
    frame_number  = '0;
    for_kernel    = 1'b0;
    writable      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    issue(REQ_TEST, '0, '0, 1'b0, 1'b0);
    issue(REQ_TEST, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
    issue(REQ_ALLOC, '0, 12'hFFF, 1'b0, 1'b1);
    issue(REQ_ALLOC, '0, '0, 1'b1, 1'b0);
    issue(REQ_ALLOC, 12'hFFF, '0, 1'b1, 1'b1);
    issue(REQ_ALLOC, 12'd1, '0, 1'b0, 1'b0);
    issue(REQ_FREE, '0, '0, 1'b0, 1'b0);
    issue(REQ_FREE, '0, 12'd1, 1'b0, 1'b0);
    issue(REQ_FREE, '0, 12'd1, 1'b1, 1'b1);
    issue(REQ_TEST, '0, '0, 1'b0, 1'b0);
    issue(REQ_TEST, '0, 12'd1, 1'b0, 1'b0);
    issue(REQ_RESERVED, 12'hFFF, 12'hFFF, 1'b1, 1'b1);
    issue(REQ_FREE, '0, 12'hFFF, 1'b0, 1'b0);
    issue(REQ_ALLOC, '0, '0, 1'b1, 1'b1);
    set_limit(0);
    issue(REQ_ALLOC, '0, '0, 1'b0, 1'b1);
    set_limit(8191);
    issue(REQ_ALLOC, '0, '0, 1'b0, 1'b0);
    set_limit(2);
    issue(REQ_ALLOC, '0, '0, 1'b1, 1'b1);
    issue(REQ_TEST, '0, 12'd2, 1'b0, 1'b0);
    issue(REQ_FREE, '0, 12'd2, 1'b0, 1'b0);
    issue(REQ_TEST, '0, 12'd2, 1'b0, 1'b0);
    issue(REQ_TEST, '0, 12'hFFF, 1'b0, 1'b0);

    // The third setting runs back to back with no pauses between requests, but for an occasional drain.
    for (int p = 0; p < 10; p++) begin
      set_limit(settings[p]);
      lim_eff = (settings[p] > 4096) ? 4096 : settings[p];
      burst = $urandom_range(1, 12);
      for (int n = 0; n < 192; n++) begin
        random_request(lim_eff);
        if (p != 2) begin
          burst--;
          if (burst == 0) begin
            pause($urandom_range(1, ($urandom_range(0, 9) == 0) ? 40 : 6));
            burst = $urandom_range(1, 12);
          end
        end
        if ($urandom_range(0, 199) == 0) drain();
      end
    end

    drain();
    repeat (140) @(negedge clk);
    $display("Covered %0d requests under %0d frame-count settings, extremes included.",
             requests_sent, limit_writes);
    $display("%0d frames granted and %0d allocations refused for want of a free frame.",
             granted_count, full_count);
    if (mismatches == 0 && awaiting == 0) begin
      $display("frame_bitmap_allocator_test: done, clean");
    end else begin
      $display("frame_bitmap_allocator_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fba_pkg.sv
rtl/fba_ram.sv
rtl/frame_bitmap_allocator.sv
tb/frame_bitmap_allocator_checker.sv
tb/frame_bitmap_allocator_test.sv
